FILE: design/msched_pkg.sv
// Shared types, codes and helpers for the multilevel process scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package msched_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  // operation codes
  localparam logic [4:0] F_CREATE  = 5'd0;
  localparam logic [4:0] F_BLOCK   = 5'd1;
  localparam logic [4:0] F_WAKEUP  = 5'd2;
  localparam logic [4:0] F_SUSPEND = 5'd3;
  localparam logic [4:0] F_RESUME  = 5'd4;
  localparam logic [4:0] F_RENICE  = 5'd5;
  localparam logic [4:0] F_SWAPOUT = 5'd6;
  localparam logic [4:0] F_PICK    = 5'd7;
  localparam logic [4:0] F_UNQUEUE = 5'd8;
  localparam logic [4:0] F_ENQUEUE = 5'd9;
  localparam logic [4:0] F_DEMOTE  = 5'd10;
  localparam logic [4:0] F_RUN     = 5'd11;
  localparam logic [4:0] F_READY   = 5'd12;
  localparam logic [4:0] F_TERM    = 5'd13;
  localparam logic [4:0] F_TICK    = 5'd14;
  localparam logic [4:0] F_SETMEM  = 5'd15;
  localparam logic [4:0] F_QUERY   = 5'd16;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADARG = 3'd1;
  localparam logic [2:0] ST_DENIED = 3'd2;
  localparam logic [2:0] ST_WRONG  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;
  localparam logic [2:0] ST_NONE   = 3'd5;

  // process states
  localparam logic [2:0] PS_READY      = 3'd0;
  localparam logic [2:0] PS_RUNNING    = 3'd1;
  localparam logic [2:0] PS_BLOCKED    = 3'd2;
  localparam logic [2:0] PS_SUSP_READY = 3'd3;
  localparam logic [2:0] PS_SUSP_BLK   = 3'd4;
  localparam logic [2:0] PS_SWAPPED    = 3'd5;
  localparam logic [2:0] PS_TERMINATED = 3'd6;

  localparam logic [1:0] LAST_LEVEL = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_FIRST = 3'd4;

  typedef struct packed {
    logic [7:0] slice0;
    logic [7:0] slice1;
    logic [7:0] slice2;
    logic [3:0] l1_first;
    logic [3:0] l2_first;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  func;
    logic [7:0]  owner;
    logic [15:0] target_pid;
    logic [15:0] parent_pid;
    logic [4:0]  new_priority;
    logic [15:0] total_ticks;
    logic [15:0] mem_kilobytes;
    logic [15:0] mem_base;
    logic [7:0]  tick_count;
  } req_t;

  // one table entry
  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  owner;
    logic [2:0]  pstate;
    logic [3:0]  prio;
    logic [1:0]  level;
    logic [15:0] run_done;
    logic [15:0] run_left;
    logic [7:0]  slice;
    logic [15:0] mem_start;
    logic [15:0] mem_size;
    logic        swapped;
    logic [1:0]  queue_at;
    logic [31:0] order;
  } rec_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pid;
    logic [2:0]  pstate;
    logic [3:0]  prio;
    logic [1:0]  level;
    logic [15:0] run_done;
    logic [15:0] run_left;
    logic [7:0]  slice;
    logic [15:0] mem_start;
    logic [15:0] mem_size;
    logic        swapped;
  } res_t;

  function automatic logic [1:0] level_for(logic [3:0] prio, cfg_t c);
    logic [1:0] l;
    if (prio < c.l1_first) l = 2'd0;
    else if (prio < c.l2_first) l = 2'd1;
    else l = 2'd2;
    return l;
  endfunction

  function automatic logic [7:0] slice_for(logic [1:0] lvl, cfg_t c);
    logic [7:0] s;
    if (lvl == 2'd0) s = c.slice0;
    else if (lvl == 2'd1) s = c.slice1;
    else s = c.slice2;
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: design/msched_ram.sv
// Generic single-port-write, single-port-read RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module msched_ram #(
  parameter int DEPTH = 16,
  parameter int DW    = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/msched_ctrl.sv
// Sequencer: table scans, pick, read-modify-write of one entry per request.
// Depends on msched_pkg and msched_ram.
`timescale 1ns / 1ps
`default_nettype none
module msched_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire msched_pkg::cfg_t  cfg,
  input  wire logic              req_vld,
  input  wire msched_pkg::req_t  req,
  output logic                   idle,
  output logic                   res_vld,
  output msched_pkg::res_t       res,
  input  wire logic              res_ready
);

  localparam int IW = msched_pkg::IDX_W;
  localparam int CW = msched_pkg::CNT_W;
  localparam int N  = msched_pkg::TABLE_SLOTS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_PA    = 3'd2;
  localparam logic [2:0] S_PB    = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]              st_r, st_nxt;
  msched_pkg::req_t        op_r, op_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           scan_r, scan_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]           chk_idx_r, chk_idx_nxt;
  logic                    own_chk_r, own_chk_nxt;
  logic [1:0]              lvl_r, lvl_nxt;
  logic                    best_vld_r, best_vld_nxt;
  logic [IW-1:0]           best_idx_r, best_idx_nxt;
  logic [31:0]             best_age_r, best_age_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [15:0]             pid_ctr_r, pid_ctr_nxt;
  logic [31:0]             ord_r, ord_nxt;
  logic [N-1:0]            queued_r, queued_nxt;
  msched_pkg::res_t        res_r, res_nxt;

  logic                    re, we;
  logic [IW-1:0]           raddr;
  msched_pkg::rec_t        rd, wr;

  logic                    scan_done, alloc_full, elig, stale, newer, match;
  logic [31:0]             age;
  logic [15:0]             key, tick_n;
  logic [2:0]              stat;
  logic                    enq, deq;

  msched_ram #(
    .DEPTH (N),
    .DW    ($bits(msched_pkg::rec_t)),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wr),
    .re    (re),
    .raddr (raddr),
    .rdata (rd)
  );

  function automatic msched_pkg::res_t fail_res(logic [2:0] s, msched_pkg::req_t q);
    msched_pkg::res_t f;
    f = '0;
    f.status = s;
    if (q.func != msched_pkg::F_CREATE && q.func != msched_pkg::F_PICK) f.pid = q.target_pid;
    return f;
  endfunction

  assign idle    = (st_r == S_IDLE);
  assign res_vld = (st_r == S_OUT);
  assign res     = res_r;

  assign scan_done  = !chk_vld_r && (scan_r >= cnt_r);
  assign alloc_full = (cnt_r == CW'(N)) || (pid_ctr_r == 16'd0);
  assign key        = (op_r.func == msched_pkg::F_CREATE) ? op_r.parent_pid : op_r.target_pid;
  assign match      = chk_vld_r && (rd.pid == key);
  assign age        = ord_r - rd.order;
  assign elig       = chk_vld_r && queued_r[chk_idx_r] && (rd.queue_at == lvl_r);
  assign stale      = (rd.pstate != msched_pkg::PS_READY) || rd.swapped;
  assign newer      = !best_vld_r || (age > best_age_r);
  assign tick_n     = ({8'd0, op_r.tick_count} < rd.run_left) ? {8'd0, op_r.tick_count}
                                                             : rd.run_left;

  always_comb begin
    st_nxt       = st_r;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    scan_nxt     = scan_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    own_chk_nxt  = own_chk_r;
    lvl_nxt      = lvl_r;
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    best_age_nxt = best_age_r;
    cnt_nxt      = cnt_r;
    pid_ctr_nxt  = pid_ctr_r;
    ord_nxt      = ord_r;
    queued_nxt   = queued_r;
    res_nxt      = res_r;
    re           = 1'b0;
    we           = 1'b0;
    raddr        = scan_r[IW-1:0];
    wr           = rd;
    stat         = msched_pkg::ST_OK;
    enq          = 1'b0;
    deq          = 1'b0;

    // pipelined table walk shared by lookup and pick passes
    if (st_r == S_LOOK || st_r == S_PA || st_r == S_PB) begin
      if (scan_r < cnt_r) begin
        re          = 1'b1;
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = scan_r[IW-1:0];
        scan_nxt    = scan_r + CW'(1);
      end
    end

    unique case (st_r)
      S_IDLE: begin
        if (req_vld) begin
          op_nxt      = req;
          scan_nxt    = '0;
          own_chk_nxt = 1'b1;
          unique case (req.func)
            msched_pkg::F_CREATE: begin
              if (req.owner == 8'd0 || req.mem_kilobytes == 16'd0 || req.new_priority[4]
                  || req.total_ticks == 16'd0) begin
                res_nxt = fail_res(msched_pkg::ST_BADARG, req);
                st_nxt  = S_OUT;
              end else if (req.parent_pid != 16'd0) begin
                st_nxt = S_LOOK;
              end else if (alloc_full) begin
                res_nxt = fail_res(msched_pkg::ST_FULL, req);
                st_nxt  = S_OUT;
              end else begin
                idx_nxt = cnt_r[IW-1:0];
                st_nxt  = S_FETCH;
              end
            end
            msched_pkg::F_BLOCK, msched_pkg::F_WAKEUP, msched_pkg::F_SUSPEND,
            msched_pkg::F_RESUME, msched_pkg::F_SWAPOUT: st_nxt = S_LOOK;
            msched_pkg::F_RENICE: begin
              if (req.new_priority[4]) begin
                res_nxt = fail_res(msched_pkg::ST_BADARG, req);
                st_nxt  = S_OUT;
              end else begin
                st_nxt = S_LOOK;
              end
            end
            msched_pkg::F_PICK: begin
              lvl_nxt      = 2'd0;
              best_vld_nxt = 1'b0;
              st_nxt       = S_PA;
            end
            msched_pkg::F_TICK: begin
              own_chk_nxt = 1'b0;
              if (req.tick_count == 8'd0) begin
                res_nxt = fail_res(msched_pkg::ST_BADARG, req);
                st_nxt  = S_OUT;
              end else begin
                st_nxt = S_LOOK;
              end
            end
            msched_pkg::F_UNQUEUE, msched_pkg::F_ENQUEUE, msched_pkg::F_DEMOTE,
            msched_pkg::F_RUN, msched_pkg::F_READY, msched_pkg::F_TERM,
            msched_pkg::F_SETMEM, msched_pkg::F_QUERY: begin
              own_chk_nxt = 1'b0;
              st_nxt      = S_LOOK;
            end
            default: begin
              res_nxt = fail_res(msched_pkg::ST_BADARG, req);
              st_nxt  = S_OUT;
            end
          endcase
        end
      end

      S_LOOK: begin
        if (match) begin
          if (own_chk_r && rd.owner != op_r.owner) begin
            res_nxt = fail_res(msched_pkg::ST_DENIED, op_r);
            st_nxt  = S_OUT;
          end else if (op_r.func == msched_pkg::F_CREATE) begin
            if (alloc_full) begin
              res_nxt = fail_res(msched_pkg::ST_FULL, op_r);
              st_nxt  = S_OUT;
            end else begin
              idx_nxt = cnt_r[IW-1:0];
              st_nxt  = S_FETCH;
            end
          end else begin
            idx_nxt = chk_idx_r;
            st_nxt  = S_FETCH;
          end
        end else if (scan_done) begin
          res_nxt = fail_res(msched_pkg::ST_DENIED, op_r);
          st_nxt  = S_OUT;
        end
      end

      // pass A: oldest live entry owned by the requester on this level
      S_PA: begin
        if (elig && !stale && rd.owner == op_r.owner && newer) begin
          best_vld_nxt = 1'b1;
          best_idx_nxt = chk_idx_r;
          best_age_nxt = age;
        end
        if (scan_done) begin
          scan_nxt = '0;
          st_nxt   = S_PB;
        end
      end

      // pass B: drop stale entries older than the choice
      S_PB: begin
        if (elig && stale && newer) queued_nxt[chk_idx_r] = 1'b0;
        if (scan_done) begin
          if (best_vld_r) begin
            queued_nxt[best_idx_r] = 1'b0;
            idx_nxt                = best_idx_r;
            st_nxt                 = S_FETCH;
          end else if (lvl_r == msched_pkg::LAST_LEVEL) begin
            res_nxt = fail_res(msched_pkg::ST_NONE, op_r);
            st_nxt  = S_OUT;
          end else begin
            lvl_nxt  = lvl_r + 2'd1;
            scan_nxt = '0;
            st_nxt   = S_PA;
          end
        end
      end

      S_FETCH: begin
        re     = 1'b1;
        raddr  = idx_r;
        st_nxt = S_EXEC;
      end

      S_EXEC: begin
        unique case (op_r.func)
          msched_pkg::F_CREATE: begin
            wr.pid       = pid_ctr_r;
            wr.owner     = op_r.owner;
            wr.pstate    = msched_pkg::PS_READY;
            wr.prio      = op_r.new_priority[3:0];
            wr.level     = msched_pkg::level_for(op_r.new_priority[3:0], cfg);
            wr.run_done  = '0;
            wr.run_left  = op_r.total_ticks;
            wr.slice     = msched_pkg::slice_for(wr.level, cfg);
            wr.mem_start = op_r.mem_base;
            wr.mem_size  = op_r.mem_kilobytes;
            wr.swapped   = 1'b0;
            enq          = 1'b1;
          end
          msched_pkg::F_BLOCK: begin
            if (rd.pstate != msched_pkg::PS_READY && rd.pstate != msched_pkg::PS_RUNNING) begin
              stat = msched_pkg::ST_WRONG;
            end else begin
              deq       = 1'b1;
              wr.pstate = msched_pkg::PS_BLOCKED;
            end
          end
          msched_pkg::F_WAKEUP: begin
            if (rd.pstate != msched_pkg::PS_BLOCKED) begin
              stat = msched_pkg::ST_WRONG;
            end else begin
              wr.pstate = msched_pkg::PS_READY;
              enq       = 1'b1;
            end
          end
          msched_pkg::F_SUSPEND: begin
            if (rd.pstate == msched_pkg::PS_READY || rd.pstate == msched_pkg::PS_RUNNING) begin
              deq       = 1'b1;
              wr.pstate = msched_pkg::PS_SUSP_READY;
            end else if (rd.pstate == msched_pkg::PS_BLOCKED) begin
              wr.pstate = msched_pkg::PS_SUSP_BLK;
            end else begin
              stat = msched_pkg::ST_WRONG;
            end
          end
          msched_pkg::F_RESUME: begin
            if (rd.pstate == msched_pkg::PS_SUSP_READY) begin
              wr.pstate = msched_pkg::PS_READY;
              enq       = 1'b1;
            end else if (rd.pstate == msched_pkg::PS_SUSP_BLK) begin
              wr.pstate = msched_pkg::PS_BLOCKED;
            end else begin
              stat = msched_pkg::ST_WRONG;
            end
          end
          msched_pkg::F_RENICE: begin
            deq      = (rd.pstate == msched_pkg::PS_READY);
            wr.prio  = op_r.new_priority[3:0];
            wr.level = msched_pkg::level_for(op_r.new_priority[3:0], cfg);
            wr.slice = msched_pkg::slice_for(wr.level, cfg);
            enq      = 1'b1;
          end
          msched_pkg::F_SWAPOUT: begin
            if (rd.swapped || rd.pstate == msched_pkg::PS_SWAPPED) begin
              stat = msched_pkg::ST_WRONG;
            end else begin
              deq          = 1'b1;
              wr.mem_start = '0;
              wr.swapped   = 1'b1;
              wr.pstate    = msched_pkg::PS_SWAPPED;
            end
          end
          msched_pkg::F_PICK: ;
          msched_pkg::F_UNQUEUE: begin
            if (!queued_r[idx_r]) stat = msched_pkg::ST_WRONG;
            else deq = 1'b1;
          end
          msched_pkg::F_ENQUEUE: begin
            if (stale) stat = msched_pkg::ST_WRONG;
            else enq = 1'b1;
          end
          msched_pkg::F_DEMOTE: begin
            if (rd.level < msched_pkg::LAST_LEVEL) wr.level = rd.level + 2'd1;
            wr.slice = msched_pkg::slice_for(wr.level, cfg);
          end
          msched_pkg::F_RUN: begin
            if (stale) begin
              stat = msched_pkg::ST_WRONG;
            end else begin
              deq       = 1'b1;
              wr.pstate = msched_pkg::PS_RUNNING;
              if (rd.slice == 8'd0) wr.slice = msched_pkg::slice_for(rd.level, cfg);
            end
          end
          msched_pkg::F_READY: begin
            if (rd.pstate == msched_pkg::PS_TERMINATED || rd.pstate == msched_pkg::PS_SWAPPED
                || rd.swapped) begin
              stat = msched_pkg::ST_WRONG;
            end else begin
              wr.pstate = msched_pkg::PS_READY;
              if (rd.slice == 8'd0) wr.slice = msched_pkg::slice_for(rd.level, cfg);
            end
          end
          msched_pkg::F_TERM: begin
            deq       = 1'b1;
            wr.pstate = msched_pkg::PS_TERMINATED;
          end
          msched_pkg::F_TICK: begin
            if (rd.pstate != msched_pkg::PS_RUNNING) begin
              stat = msched_pkg::ST_WRONG;
            end else begin
              wr.run_done = rd.run_done + tick_n;
              wr.run_left = rd.run_left - tick_n;
              wr.slice    = ({8'd0, rd.slice} > tick_n) ? 8'(rd.slice - tick_n[7:0]) : 8'd0;
            end
          end
          msched_pkg::F_SETMEM: wr.mem_start = op_r.mem_base;
          default: ;
        endcase

        if (stat == msched_pkg::ST_OK) begin
          if (op_r.func == msched_pkg::F_CREATE) begin
            cnt_nxt     = cnt_r + CW'(1);
            pid_ctr_nxt = pid_ctr_r + 16'd1;
          end
          if (deq) queued_nxt[idx_r] = 1'b0;
          if (enq && wr.pstate == msched_pkg::PS_READY) begin
            queued_nxt[idx_r] = 1'b1;
            wr.queue_at       = wr.level;
            wr.order          = ord_r;
            ord_nxt           = ord_r + 32'd1;
          end
          we                = 1'b1;
          res_nxt.status    = msched_pkg::ST_OK;
          res_nxt.pid       = wr.pid;
          res_nxt.pstate    = wr.pstate;
          res_nxt.prio      = wr.prio;
          res_nxt.level     = wr.level;
          res_nxt.run_done  = wr.run_done;
          res_nxt.run_left  = wr.run_left;
          res_nxt.slice     = wr.slice;
          res_nxt.mem_start = wr.mem_start;
          res_nxt.mem_size  = wr.mem_size;
          res_nxt.swapped   = wr.swapped;
        end else begin
          res_nxt = fail_res(stat, op_r);
        end
        st_nxt = S_OUT;
      end

      S_OUT: begin
        if (res_ready) st_nxt = S_IDLE;
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      chk_vld_r  <= 1'b0;
      cnt_r      <= '0;
      pid_ctr_r  <= 16'd1;
      ord_r      <= '0;
      queued_r   <= '0;
      best_vld_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      chk_vld_r  <= chk_vld_nxt;
      cnt_r      <= cnt_nxt;
      pid_ctr_r  <= pid_ctr_nxt;
      ord_r      <= ord_nxt;
      queued_r   <= queued_nxt;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    scan_r     <= scan_nxt;
    chk_idx_r  <= chk_idx_nxt;
    own_chk_r  <= own_chk_nxt;
    lvl_r      <= lvl_nxt;
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
    res_r      <= res_nxt;
  end

endmodule
`default_nettype wire

FILE: design/multilevel_process_scheduler_core.sv
// Top level of the multilevel process scheduler: ports, config registers, result register.
// Depends on msched_pkg and msched_ctrl.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   in_*  : one request per accept (in_valid high, in_stall low). Each request
//           carries one scheduler operation selected by in_func.
//   out_* : exactly one result per request, in order, held while out_stall.
//   cfg_* : register writes (index, data); cfg_ready is always high. Write only
//           while no request is in flight.
// Request flow (N = table slots in use, at most 16):
//   bad-argument rejects and create without parent need no table walk.
//   pid lookups: one table walk over the N entries in use through the
//   entry RAM (one read per cycle, registered data).
//   pick: two walks (pass A, pass B) per level tried, up to three levels.
//   One request at a time.
// A new request is taken while a finished result still waits in the output
// register; the next result waits internally until that register frees up.
// Reset: empty table, pid counter at 1, config registers at their defaults.
module multilevel_process_scheduler_core (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  in_func,
  input  wire logic [7:0]  in_owner_id,
  input  wire logic [15:0] in_target_pid,
  input  wire logic [15:0] in_parent_pid,
  input  wire logic [4:0]  in_new_priority,
  input  wire logic [15:0] in_total_ticks,
  input  wire logic [15:0] in_mem_kilobytes,
  input  wire logic [15:0] in_mem_base,
  input  wire logic [7:0]  in_tick_count,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_result_pid,
  output logic [2:0]       out_proc_state,
  output logic [3:0]       out_proc_priority,
  output logic [1:0]       out_queue_level,
  output logic [15:0]      out_run_done,
  output logic [15:0]      out_run_left,
  output logic [7:0]       out_slice_remaining,
  output logic [15:0]      out_mem_start_out,
  output logic [15:0]      out_mem_size_out,
  output logic             out_is_swapped,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [msched_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]  cfg_data
);

  msched_pkg::cfg_t cfg_r, cfg_nxt;
  msched_pkg::req_t req;
  msched_pkg::res_t res, out_r;
  logic             out_valid_r;
  logic             idle, res_vld, res_take;

  // config port never pushes back
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        msched_pkg::CFG_SLICE0:   cfg_nxt.slice0   = cfg_data;
        msched_pkg::CFG_SLICE1:   cfg_nxt.slice1   = cfg_data;
        msched_pkg::CFG_SLICE2:   cfg_nxt.slice2   = cfg_data;
        msched_pkg::CFG_L1_FIRST: cfg_nxt.l1_first = cfg_data[3:0];
        msched_pkg::CFG_L2_FIRST: cfg_nxt.l2_first = cfg_data[3:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slice0   <= 8'd2;
      cfg_r.slice1   <= 8'd4;
      cfg_r.slice2   <= 8'd8;
      cfg_r.l1_first <= 4'd4;
      cfg_r.l2_first <= 4'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign req.func          = in_func;
  assign req.owner         = in_owner_id;
  assign req.target_pid    = in_target_pid;
  assign req.parent_pid    = in_parent_pid;
  assign req.new_priority  = in_new_priority;
  assign req.total_ticks   = in_total_ticks;
  assign req.mem_kilobytes = in_mem_kilobytes;
  assign req.mem_base      = in_mem_base;
  assign req.tick_count    = in_tick_count;

  // sequencer takes one request at a time
  assign in_stall = !idle;

  msched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_vld   (in_valid && !in_stall),
    .req       (req),
    .idle      (idle),
    .res_vld   (res_vld),
    .res       (res),
    .res_ready (res_take)
  );

  // output register: free when empty or being drained this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_take) out_r <= res;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_result_pid      = out_r.pid;
  assign out_proc_state      = out_r.pstate;
  assign out_proc_priority   = out_r.prio;
  assign out_queue_level     = out_r.level;
  assign out_run_done        = out_r.run_done;
  assign out_run_left        = out_r.run_left;
  assign out_slice_remaining = out_r.slice;
  assign out_mem_start_out   = out_r.mem_start;
  assign out_mem_size_out    = out_r.mem_size;
  assign out_is_swapped      = out_r.swapped;

endmodule
`default_nettype wire

FILE: dv/msched_checker.sv
// Checker for the multilevel process scheduler: keeps a model of the process
// table, predicts one result per accepted request and compares results in order.
// Depends on msched_pkg.
`timescale 1ns / 1ps
module msched_checker
  import msched_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  in_func,
  input  logic [7:0]  in_owner_id,
  input  logic [15:0] in_target_pid,
  input  logic [15:0] in_parent_pid,
  input  logic [4:0]  in_new_priority,
  input  logic [15:0] in_total_ticks,
  input  logic [15:0] in_mem_kilobytes,
  input  logic [15:0] in_mem_base,
  input  logic [7:0]  in_tick_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_result_pid,
  input  logic [2:0]  out_proc_state,
  input  logic [3:0]  out_proc_priority,
  input  logic [1:0]  out_queue_level,
  input  logic [15:0] out_run_done,
  input  logic [15:0] out_run_left,
  input  logic [7:0]  out_slice_remaining,
  input  logic [15:0] out_mem_start_out,
  input  logic [15:0] out_mem_size_out,
  input  logic        out_is_swapped,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int NSLOT = 16;

  // model of the process table
  bit          used[NSLOT];
  logic [15:0] pidv[NSLOT];
  logic [7:0]  own[NSLOT];
  logic [2:0]  pst[NSLOT];
  logic [3:0]  prio[NSLOT];
  logic [1:0]  lvl[NSLOT];
  logic [15:0] rdone[NSLOT];
  logic [15:0] rleft[NSLOT];
  logic [7:0]  slc[NSLOT];
  logic [15:0] mstart[NSLOT];
  logic [15:0] msize[NSLOT];
  bit          swp[NSLOT];
  bit          queued[NSLOT];
  logic [1:0]  qat[NSLOT];
  logic [31:0] ord[NSLOT];
  logic [15:0] next_pid;
  logic [31:0] order_cnt;
  cfg_t        sched_cfg;

  res_t expected_results[$];

  function automatic int find_entry(logic [15:0] pid);
    for (int i = 0; i < NSLOT; i++)
      if (used[i] && pidv[i] == pid) return i;
    return -1;
  endfunction

  function automatic int find_owned_entry(logic [15:0] pid, logic [7:0] owner);
    int i;
    i = find_entry(pid);
    if (i >= 0 && own[i] != owner) return -1;
    return i;
  endfunction

  function automatic logic [1:0] ready_level(logic [3:0] p);
    if (p < sched_cfg.l1_first) return 2'd0;
    if (p < sched_cfg.l2_first) return 2'd1;
    return 2'd2;
  endfunction

  function automatic logic [7:0] level_slice(logic [1:0] l);
    if (l == 2'd0) return sched_cfg.slice0;
    if (l == 2'd1) return sched_cfg.slice1;
    return sched_cfg.slice2;
  endfunction

  function automatic void join_ready(int i);
    if (pst[i] != PS_READY) return;
    queued[i] = 1'b1;
    qat[i]    = lvl[i];
    ord[i]    = order_cnt;
    order_cnt = order_cnt + 32'd1;
  endfunction

  // oldest owned ready entry of the lowest level; stale entries passed over are dropped
  function automatic int pick_oldest(logic [7:0] owner);
    bit          seen[NSLOT];
    int          best;
    logic [31:0] best_age;
    logic [31:0] age;
    for (int l = 0; l < 3; l++) begin
      foreach (seen[i]) seen[i] = 1'b0;
      forever begin
        best = -1;
        best_age = '0;
        for (int i = 0; i < NSLOT; i++) begin
          if (!(used[i] && queued[i] && qat[i] == l[1:0] && !seen[i])) continue;
          age = order_cnt - ord[i];
          if (best < 0 || age > best_age) begin
            best = i;
            best_age = age;
          end
        end
        if (best < 0) break;
        seen[best] = 1'b1;
        if (pst[best] != PS_READY || swp[best]) begin
          queued[best] = 1'b0;
          continue;
        end
        if (own[best] != owner) continue;
        queued[best] = 1'b0;
        return best;
      end
    end
    return -1;
  endfunction

  function automatic res_t sched_predict(req_t r);
    res_t        res;
    logic [2:0]  status;
    int          i;
    logic [15:0] n;
    status = ST_OK;
    i = -1;
    res = '0;
    case (r.func)
      F_CREATE: begin
        if (r.owner == 0 || r.mem_kilobytes == 0 || r.new_priority > 15 ||
            r.total_ticks == 0) status = ST_BADARG;
        else if (r.parent_pid != 0 && find_owned_entry(r.parent_pid, r.owner) < 0)
          status = ST_DENIED;
        else begin
          for (int k = 0; k < NSLOT; k++)
            if (!used[k]) begin
              i = k;
              break;
            end
          if (i < 0 || next_pid == 0) begin
            i = -1;
            status = ST_FULL;
          end else begin
            used[i]   = 1'b1;
            pidv[i]   = next_pid;
            next_pid  = next_pid + 16'd1;
            own[i]    = r.owner;
            pst[i]    = PS_READY;
            prio[i]   = r.new_priority[3:0];
            lvl[i]    = ready_level(prio[i]);
            rdone[i]  = '0;
            rleft[i]  = r.total_ticks;
            slc[i]    = level_slice(lvl[i]);
            mstart[i] = r.mem_base;
            msize[i]  = r.mem_kilobytes;
            swp[i]    = 1'b0;
            queued[i] = 1'b0;
            join_ready(i);
          end
        end
      end
      F_BLOCK, F_WAKEUP, F_SUSPEND, F_RESUME, F_SWAPOUT: begin
        i = find_owned_entry(r.target_pid, r.owner);
        if (i < 0) status = ST_DENIED;
        else if (r.func == F_BLOCK) begin
          if (pst[i] != PS_READY && pst[i] != PS_RUNNING) status = ST_WRONG;
          else begin
            queued[i] = 1'b0;
            pst[i] = PS_BLOCKED;
          end
        end else if (r.func == F_WAKEUP) begin
          if (pst[i] != PS_BLOCKED) status = ST_WRONG;
          else begin
            pst[i] = PS_READY;
            join_ready(i);
          end
        end else if (r.func == F_SUSPEND) begin
          if (pst[i] == PS_READY || pst[i] == PS_RUNNING) begin
            queued[i] = 1'b0;
            pst[i] = PS_SUSP_READY;
          end else if (pst[i] == PS_BLOCKED) pst[i] = PS_SUSP_BLK;
          else status = ST_WRONG;
        end else if (r.func == F_RESUME) begin
          if (pst[i] == PS_SUSP_READY) begin
            pst[i] = PS_READY;
            join_ready(i);
          end else if (pst[i] == PS_SUSP_BLK) pst[i] = PS_BLOCKED;
          else status = ST_WRONG;
        end else begin
          if (swp[i] || pst[i] == PS_SWAPPED) status = ST_WRONG;
          else begin
            queued[i] = 1'b0;
            mstart[i] = '0;
            swp[i]    = 1'b1;
            pst[i]    = PS_SWAPPED;
          end
        end
      end
      F_RENICE: begin
        if (r.new_priority > 15) status = ST_BADARG;
        else begin
          i = find_owned_entry(r.target_pid, r.owner);
          if (i < 0) status = ST_DENIED;
          else begin
            if (pst[i] == PS_READY) queued[i] = 1'b0;
            prio[i] = r.new_priority[3:0];
            lvl[i]  = ready_level(prio[i]);
            slc[i]  = level_slice(lvl[i]);
            join_ready(i);
          end
        end
      end
      F_PICK: begin
        i = pick_oldest(r.owner);
        if (i < 0) status = ST_NONE;
      end
      F_UNQUEUE, F_ENQUEUE, F_DEMOTE, F_RUN, F_READY, F_TERM, F_TICK, F_SETMEM,
      F_QUERY: begin
        if (r.func == F_TICK && r.tick_count == 0) status = ST_BADARG;
        else begin
          i = find_entry(r.target_pid);
          if (i < 0) status = ST_DENIED;
          else case (r.func)
            F_UNQUEUE:
              if (!queued[i]) status = ST_WRONG;
              else queued[i] = 1'b0;
            F_ENQUEUE:
              if (pst[i] != PS_READY || swp[i]) status = ST_WRONG;
              else join_ready(i);
            F_DEMOTE: begin
              if (lvl[i] < LAST_LEVEL) lvl[i] = lvl[i] + 2'd1;
              slc[i] = level_slice(lvl[i]);
            end
            F_RUN:
              if (pst[i] != PS_READY || swp[i]) status = ST_WRONG;
              else begin
                queued[i] = 1'b0;
                pst[i] = PS_RUNNING;
                if (slc[i] == 0) slc[i] = level_slice(lvl[i]);
              end
            F_READY:
              if (pst[i] == PS_TERMINATED || pst[i] == PS_SWAPPED || swp[i])
                status = ST_WRONG;
              else begin
                pst[i] = PS_READY;
                if (slc[i] == 0) slc[i] = level_slice(lvl[i]);
              end
            F_TERM: begin
              queued[i] = 1'b0;
              pst[i] = PS_TERMINATED;
            end
            F_TICK:
              if (pst[i] != PS_RUNNING) status = ST_WRONG;
              else begin
                n = (r.tick_count < rleft[i]) ? 16'(r.tick_count) : rleft[i];
                rdone[i] = rdone[i] + n;
                rleft[i] = rleft[i] - n;
                slc[i]   = (slc[i] > n) ? slc[i] - n[7:0] : 8'd0;
              end
            F_SETMEM: mstart[i] = r.mem_base;
            default: ;
          endcase
        end
      end
      default: status = ST_BADARG;
    endcase
    res.status = status;
    if (status == ST_OK && i >= 0) begin
      res.pid       = pidv[i];
      res.pstate    = pst[i];
      res.prio      = prio[i];
      res.level     = lvl[i];
      res.run_done  = rdone[i];
      res.run_left  = rleft[i];
      res.slice     = slc[i];
      res.mem_start = mstart[i];
      res.mem_size  = msize[i];
      res.swapped   = swp[i];
    end else begin
      res.pid = (r.func == F_CREATE || r.func == F_PICK) ? 16'd0 : r.target_pid;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    req_t r;
    res_t e;
    if (!rst_n) begin
      foreach (used[i]) begin
        used[i] = 1'b0;
        queued[i] = 1'b0;
      end
      next_pid  = 16'd1;
      order_cnt = '0;
      sched_cfg = '{slice0: 8'd2, slice1: 8'd4, slice2: 8'd8, l1_first: 4'd4,
                    l2_first: 4'd8};
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding (pid %0d)", out_result_pid);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, out_status);
          check_field("result_pid", e.pid, out_result_pid);
          check_field("proc_state", e.pstate, out_proc_state);
          check_field("proc_priority", e.prio, out_proc_priority);
          check_field("queue_level", e.level, out_queue_level);
          check_field("run_done", e.run_done, out_run_done);
          check_field("run_left", e.run_left, out_run_left);
          check_field("slice_remaining", e.slice, out_slice_remaining);
          check_field("mem_start_out", e.mem_start, out_mem_start_out);
          check_field("mem_size_out", e.mem_size, out_mem_size_out);
          check_field("is_swapped", e.swapped, out_is_swapped);
        end
      end
      if (in_valid && !in_stall) begin
        r = '{func: in_func, owner: in_owner_id, target_pid: in_target_pid,
              parent_pid: in_parent_pid, new_priority: in_new_priority,
              total_ticks: in_total_ticks, mem_kilobytes: in_mem_kilobytes,
              mem_base: in_mem_base, tick_count: in_tick_count};
        e = sched_predict(r);
        expected_results = {expected_results, e};
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLICE0:   sched_cfg.slice0 = cfg_data;
          CFG_SLICE1:   sched_cfg.slice1 = cfg_data;
          CFG_SLICE2:   sched_cfg.slice2 = cfg_data;
          CFG_L1_FIRST: sched_cfg.l1_first = cfg_data[3:0];
          CFG_L2_FIRST: sched_cfg.l2_first = cfg_data[3:0];
          default: ;
        endcase
      end
    end
    // registered so the stimulus side sees a settled count at the next edge
    pending <= expected_results.size();
  end

endmodule

FILE: dv/multilevel_process_scheduler_core_tb.sv
// Testbench top for the multilevel process scheduler: clock, reset, request and
// config stimulus, result-side stall, verdict. Depends on msched_pkg, msched_checker
// and the multilevel_process_scheduler_core RTL.
`timescale 1ns / 1ps
module multilevel_process_scheduler_core_tb;
  import msched_pkg::*;

  localparam int RANDOM_REQS = 650;
  localparam int PHASES      = 5;
  // settle time, well past the worst pick walk
  localparam int SETTLE      = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_func = '0;
  logic [7:0]  in_owner_id = '0;
  logic [15:0] in_target_pid = '0;
  logic [15:0] in_parent_pid = '0;
  logic [4:0]  in_new_priority = '0;
  logic [15:0] in_total_ticks = '0;
  logic [15:0] in_mem_kilobytes = '0;
  logic [15:0] in_mem_base = '0;
  logic [7:0]  in_tick_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_result_pid;
  logic [2:0]  out_proc_state;
  logic [3:0]  out_proc_priority;
  logic [1:0]  out_queue_level;
  logic [15:0] out_run_done;
  logic [15:0] out_run_left;
  logic [7:0]  out_slice_remaining;
  logic [15:0] out_mem_start_out;
  logic [15:0] out_mem_size_out;
  logic        out_is_swapped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  int fail_count;
  int pending;

  // idling control, shared between the request and result processes
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit long_hold = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multilevel_process_scheduler_core dut (.*);

  msched_checker u_checker (.*);

  // run guard: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("multilevel_process_scheduler_core_tb: done, errors");
    $finish;
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until taken. Valid stays high on return,
  // so the caller must drive the next request or drop valid in the same step.
  task automatic send_req(logic [4:0] f, logic [7:0] owner, logic [15:0] tpid,
                          logic [15:0] ppid, logic [4:0] prio, logic [15:0] total,
                          logic [15:0] kb, logic [15:0] base, logic [7:0] ticks);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= f;
    in_owner_id      <= owner;
    in_target_pid    <= tpid;
    in_parent_pid    <= ppid;
    in_new_priority  <= prio;
    in_total_ticks   <= total;
    in_mem_kilobytes <= kb;
    in_mem_base      <= base;
    in_tick_count    <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait for every outstanding result, plus walk time;
  // the first edge lets the count take in the last accepted request
  task automatic drain(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // valid stays high on return; the caller drops it after the last write
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // mostly well-formed scheduler traffic on pids 0..18 from three owners
  // and the odd owner 0, the rest full-range noise
  task automatic random_req();
    int          r;
    logic [4:0]  f;
    logic [7:0]  owner;
    logic [4:0]  prio;
    r = $urandom_range(0, 99);
    owner = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
    prio  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(16, 31))
                                        : 5'($urandom_range(0, 15));
    if (r < 10) begin
      send_req(F_CREATE, owner,
               16'($urandom), ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 18)) : 16'd0,
               prio, 16'($urandom_range(1, 300)), 16'($urandom_range(1, 65535)),
               16'($urandom), 8'($urandom));
    end else if (r < 86) begin
      // lean toward the ops that move entries through the levels
      if (r < 30) f = ($urandom_range(0, 1) != 0) ? F_PICK : F_RUN;
      else if (r < 40) f = ($urandom_range(0, 1) != 0) ? F_TICK : F_READY;
      else f = 5'($urandom_range(1, 16));
      send_req(f, owner, 16'($urandom_range(0, 18)), 16'($urandom), prio,
               16'($urandom), 16'($urandom), 16'($urandom),
               ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 40)));
    end else begin
      send_req(5'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 5'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] settings[PHASES][5];
    settings[0] = '{8'd1, 8'd1, 8'd1, 8'd0, 8'd0};
    settings[1] = '{8'd255, 8'd255, 8'd255, 8'd15, 8'd15};
    settings[2] = '{8'd0, 8'd7, 8'd200, 8'd15, 8'd0};
    settings[3] = '{8'd3, 8'd5, 8'd9, 8'd2, 8'd10};
    settings[4] = '{8'd255, 8'd1, 8'd128, 8'd8, 8'd4};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: argument checks, parent checks, every operation, odd codes
    send_req(F_CREATE, 8'd0, 0, 0, 5'd1, 16'd10, 16'd4, 16'd0, 0);     // not logged in
    send_req(F_CREATE, 8'd1, 0, 0, 5'd1, 16'd10, 16'd0, 16'd0, 0);     // no memory
    send_req(F_CREATE, 8'd1, 0, 0, 5'd31, 16'd10, 16'd4, 16'd0, 0);    // bad priority
    send_req(F_CREATE, 8'd1, 0, 0, 5'd1, 16'd0, 16'd4, 16'd0, 0);      // no run time
    send_req(F_CREATE, 8'd1, 0, 16'd99, 5'd1, 16'd10, 16'd4, 16'd0, 0); // unknown parent
    send_req(F_CREATE, 8'd1, 0, 0, 5'd0, 16'd65535, 16'd65535, 16'hFFFF, 0);
    send_req(F_CREATE, 8'd2, 0, 16'd1, 5'd5, 16'd10, 16'd4, 16'd0, 0); // parent not owned
    send_req(F_CREATE, 8'd1, 0, 16'd1, 5'd9, 16'd30, 16'd8, 16'd100, 0);
    send_req(F_CREATE, 8'd255, 0, 0, 5'd15, 16'd5, 16'd1, 16'd7, 0);
    send_req(5'd17, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0);
    send_req(5'd31, 8'd1, 16'd2, 0, 0, 0, 0, 0, 0);
    send_req(F_PICK, 8'd7, 0, 0, 0, 0, 0, 0, 0);                       // nothing owned
    send_req(F_PICK, 8'd1, 0, 0, 0, 0, 0, 0, 0);
    send_req(F_RUN, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0);
    send_req(F_TICK, 8'd1, 16'd1, 0, 0, 0, 0, 0, 8'd0);                // zero ticks
    send_req(F_TICK, 8'd1, 16'd1, 0, 0, 0, 0, 0, 8'd255);
    send_req(F_BLOCK, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0);
    send_req(F_WAKEUP, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0);
    send_req(F_SUSPEND, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0);
    send_req(F_RESUME, 8'd1, 16'd1, 0, 0, 0, 0, 0, 0);
    send_req(F_RENICE, 8'd1, 16'd2, 0, 5'd15, 0, 0, 0, 0);
    send_req(F_SWAPOUT, 8'd1, 16'd2, 0, 0, 0, 0, 0, 0);
    send_req(F_SETMEM, 8'd0, 16'd2, 0, 0, 0, 0, 16'hA5A5, 0);
    send_req(F_ENQUEUE, 8'd0, 16'd3, 0, 0, 0, 0, 0, 0);
    send_req(F_UNQUEUE, 8'd0, 16'd3, 0, 0, 0, 0, 0, 0);
    send_req(F_UNQUEUE, 8'd0, 16'd3, 0, 0, 0, 0, 0, 0);                // no longer queued
    send_req(F_DEMOTE, 8'd0, 16'd3, 0, 0, 0, 0, 0, 0);
    send_req(F_READY, 8'd0, 16'd1, 0, 0, 0, 0, 0, 0);
    send_req(F_TERM, 8'd0, 16'd3, 0, 0, 0, 0, 0, 0);
    send_req(F_QUERY, 8'd0, 16'hFFFF, 0, 0, 0, 0, 0, 0);

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain(SETTLE);
      for (int k = 0; k < 5; k++) write_cfg(CFG_IDX_W'(k), settings[p][k]);
      cfg_valid <= 1'b0;
      if (p == PHASES - 1) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      for (int n = 0; n < RANDOM_REQS / PHASES; n++) begin
        if (p == 1 && n == 5) long_hold = 1'b1;   // fill the block, back up the input
        if (p == 2 && n == 60) drain(0);           // let everything come home mid-phase
        random_req();
      end
    end

    drain(SETTLE);
    if (fail_count == 0) begin
      $display("multilevel_process_scheduler_core_tb: done, clean");
    end else begin
      $display("multilevel_process_scheduler_core_tb: done, errors");
    end
    $finish;
  end

endmodule
